>>> design/hvt_pkg.sv
package hvt_pkg;

  localparam int NCFG = 8;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_POINT_DIV = 2'd0,
    OP_POINT     = 2'd1,
    OP_NORMAL    = 2'd2,
    OP_VEC4      = 2'd3
  } op_t;

  typedef logic [3:0][31:0] vec_t;
  typedef logic [3:0][3:0][31:0] mat_t;

  typedef struct packed {
    logic        div_en;
    logic        sat;
    logic        dz;
    logic [2:0]  neg;
    vec_t        res;
  } side_t;

endpackage

>>> design/hvt_cfg.sv
module hvt_cfg import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output mat_t        mat
);

  localparam logic [2:0] REG_R0C01 = 3'd0;
  localparam logic [2:0] REG_R0C23 = 3'd1;
  localparam logic [2:0] REG_R1C01 = 3'd2;
  localparam logic [2:0] REG_R1C23 = 3'd3;
  localparam logic [2:0] REG_R2C01 = 3'd4;
  localparam logic [2:0] REG_R2C23 = 3'd5;
  localparam logic [2:0] REG_R3C01 = 3'd6;
  localparam logic [2:0] REG_R3C23 = 3'd7;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  logic [63:0] regs [NCFG];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_R0C01] <= ONE_LO;
      regs[REG_R0C23] <= '0;
      regs[REG_R1C01] <= ONE_HI;
      regs[REG_R1C23] <= '0;
      regs[REG_R2C01] <= '0;
      regs[REG_R2C23] <= ONE_LO;
      regs[REG_R3C01] <= '0;
      regs[REG_R3C23] <= ONE_HI;
    end else if (psel && penable && pwrite) begin
      regs[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = regs[paddr[5:3]];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs[2*r][31:0];
      mat[r][1] = regs[2*r][63:32];
      mat[r][2] = regs[2*r+1][31:0];
      mat[r][3] = regs[2*r+1][63:32];
    end
  end

endmodule

>>> design/hvt_mac.sv
module hvt_mac import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  op_t  in_op,
  input  vec_t in_vec,
  input  mat_t mat,
  output logic out_valid,
  output op_t  out_op,
  output vec_t out_res,
  output logic out_sat
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic [3:0] vld;
  op_t        op1, op2, op3, op4;
  vec_t       vec1;
  logic signed [63:0] prod [4][4];
  logic signed [64:0] pair [2][4];
  logic signed [65:0] tot [4];
  logic signed [65:0] sh [4];
  vec_t       res_next;
  logic       sat_next;
  logic       fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= in_op;
      vec1[2:0] <= in_vec[2:0];
      case (in_op)
        OP_VEC4:   vec1[3] <= in_vec[3];
        OP_NORMAL: vec1[3] <= '0;
        default:   vec1[3] <= ONE;
      endcase
      op2 <= op1;
      op3 <= op2;
      op4 <= op3;
      out_op <= op4;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= $signed(vec1[r]) * $signed(mat[r][c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        pair[0][c] <= 65'(prod[0][c]) + 65'(prod[1][c]);
        pair[1][c] <= 65'(prod[2][c]) + 65'(prod[3][c]);
        tot[c] <= 66'(pair[0][c]) + 66'(pair[1][c]);
      end
      out_res <= res_next;
      out_sat <= sat_next;
    end
  end

  always_comb begin
    sat_next = 1'b0;
    fits = 1'b1;
    for (int c = 0; c < 4; c++) begin
      sh[c] = tot[c] >>> FRAC_BITS;
      fits = (&sh[c][65:31]) | ~(|sh[c][65:31]);
      if (fits) begin
        res_next[c] = sh[c][31:0];
      end else begin
        res_next[c] = sh[c][65] ? Q_MIN : Q_MAX;
        sat_next = 1'b1;
      end
    end
  end

endmodule

>>> design/hvt_div.sv
module hvt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [32+FRAC_BITS-1:0] num,
  input  logic [31:0]             den,
  output logic [32+FRAC_BITS-1:0] quo
);

  localparam int DW = 32 + FRAC_BITS;

  logic [31:0]   rem_q [DW];
  logic [DW-1:0] aq_q  [DW];
  logic [31:0]   dv_q  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [31:0]   rem_s;
    logic [DW-1:0] aq_s;
    logic [31:0]   dv_s;
    logic [32:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign aq_s  = num;
      assign dv_s  = den;
    end else begin : g_rest
      assign rem_s = rem_q[k-1];
      assign aq_s  = aq_q[k-1];
      assign dv_s  = dv_q[k-1];
    end

    assign t  = {rem_s, aq_s[DW-1]};
    assign ge = t >= {1'b0, dv_s};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? 32'(t - {1'b0, dv_s}) : t[31:0];
        aq_q[k]  <= {aq_s[DW-2:0], ge};
        dv_q[k]  <= dv_s;
      end
    end
  end

  assign quo = aq_q[DW-1];

endmodule

>>> design/homogeneous_vertex_transform.sv
// throughput: one transaction per cycle; the whole pipeline holds while the output stalls
// stages: input, multiply, two adder levels, shift and clip, divider set-up,
// one restoring divider step per quotient bit (32 + FRAC_BITS), output register
// reset: synchronous, clears all valid bits and loads the identity matrix
module homogeneous_vertex_transform import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // in_x, in_y, in_z, in_w
  input  logic [1:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_w
  output logic [1:0]   m_tuser,   // saturated, divide_by_zero
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int DW = 32 + FRAC_BITS;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
  localparam logic [DW-1:0] MAG_MAX = DW'(Q_MAX);
  localparam logic [DW-1:0] MAG_MIN = DW'(Q_MIN);

  logic          adv;
  mat_t          mat;
  logic          mac_valid;
  op_t           mac_op;
  vec_t          mac_res;
  logic          mac_sat;
  logic [DW:0]   vld;
  side_t         side [DW+1];
  side_t         prep_next;
  logic [DW-1:0] num [3];
  logic [31:0]   den;
  logic [DW-1:0] quo [3];
  logic [31:0]   wv;
  logic [31:0]   mag;
  logic [DW-1:0] negm;
  logic          over;
  vec_t          res_next;
  logic          sat_next;

  assign pready = 1'b1;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  hvt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .mat(mat)
  );

  hvt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s_tvalid), .in_op(op_t'(s_tuser)),
    .in_vec(s_tdata), .mat(mat), .out_valid(mac_valid), .out_op(mac_op),
    .out_res(mac_res), .out_sat(mac_sat)
  );

  // divider set-up: magnitudes and quotient signs
  always_comb begin
    wv = mac_res[3];
    prep_next.res = mac_res;
    prep_next.sat = mac_sat;
    prep_next.dz = (mac_op == OP_POINT_DIV) && (wv == '0);
    prep_next.div_en = (mac_op == OP_POINT_DIV) && (wv != '0);
    if (prep_next.dz) prep_next.res = '0;
    if (mac_op == OP_NORMAL) prep_next.res[3] = '0;
    for (int c = 0; c < 3; c++) begin
      prep_next.neg[c] = mac_res[c][31] ^ wv[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[DW-1:0], mac_valid};
      m_tvalid <= vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= prep_next;
      den <= !prep_next.div_en ? 32'd1 : (wv[31] ? 32'(-wv) : wv);
      for (int c = 0; c < 3; c++) begin
        num[c] <= {(mac_res[c][31] ? 32'(-mac_res[c]) : mac_res[c]), {FRAC_BITS{1'b0}}};
      end
      for (int k = 1; k <= DW; k++) begin
        side[k] <= side[k-1];
      end
      m_tdata <= res_next;
      m_tuser <= {side[DW].dz, sat_next};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    hvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(adv), .num(num[c]), .den(den), .quo(quo[c])
    );
  end

  // sign, clip and final selection
  always_comb begin
    res_next = side[DW].res;
    sat_next = side[DW].sat;
    mag = '0;
    negm = '0;
    over = 1'b0;
    if (side[DW].div_en) begin
      res_next[3] = ONE;
      for (int c = 0; c < 3; c++) begin
        negm = DW'(-quo[c]);
        if (side[DW].neg[c]) begin
          over = quo[c] > MAG_MIN;
          mag = over ? Q_MIN : negm[31:0];
        end else begin
          over = quo[c] > MAG_MAX;
          mag = over ? Q_MAX : quo[c][31:0];
        end
        res_next[c] = mag;
        sat_next = sat_next | over;
      end
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0)
    else $error("divide by zero result not cleared");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule
